### hdl/sram_bank_mapper_with_device_windows_unit_defines.svh
// assertion macros for the verification files of the bank mapper
`ifndef SRAM_BANK_MAPPER_WITH_DEVICE_WINDOWS_UNIT_DEFINES_SVH
`define SRAM_BANK_MAPPER_WITH_DEVICE_WINDOWS_UNIT_DEFINES_SVH

// clocked check, ignored while reset is asserted
`define SBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define SBM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sbm_pkg.sv
// shared types and constants of the sram bank mapper
package sbm_pkg;

	// widest bank number the field layout allows
	localparam int BANK_W = 7;
	localparam int ADDR_W = 15;
	localparam int SRAM_W = 20;
	localparam int PADDR_W = 3;

	// access kind on the input side
	localparam logic OP_WRITE = 1'b1;

	// register select (paddr bit 2)
	localparam logic REG_BOARD_TYPE = 1'b0;
	localparam logic REG_BANK_MASK = 1'b1;

	// high control bits value that opens the scsi window on page 0
	localparam logic [1:0] HIGH_SCSI = 2'b01;

	typedef enum logic [2:0] {
		TGT_SRAM      = 3'd0,
		TGT_SOUND     = 3'd1,
		TGT_SCSI_DATA = 3'd2,
		TGT_SCSI_REG  = 3'd3,
		TGT_CTRL      = 3'd4,
		TGT_NONE      = 3'd5
	} target_t;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
	} sbm_item_t;

	typedef struct packed {
		target_t           target;
		logic [SRAM_W-1:0] sram_address;
		logic [7:0]        device_offset;
		logic              write_strobe;
		logic [7:0]        data_out;
	} sbm_result_t;

endpackage

### hdl/sbm_decode.sv
// access decode and next mapper state for one bus access
module sbm_decode import sbm_pkg::*; #(
	parameter int BANK_BITS = 7
) (
	input  sbm_item_t            item,
	input  logic                 board_type,
	input  logic [BANK_W-1:0]    bank_mask,
	input  logic [BANK_BITS-1:0] bank_cur [4],
	input  logic [1:0]           high_cur,
	input  logic                 sound_cur,
	output sbm_result_t          res,
	output logic [BANK_BITS-1:0] bank_nxt [4],
	output logic [1:0]           high_nxt,
	output logic                 sound_nxt
);

	localparam logic [BANK_W-1:0] LIMIT = BANK_W'((1 << BANK_BITS) - 1);

	logic [1:0]        page;
	logic [12:0]       off;
	logic              wr;
	logic              scsi;
	logic              we;
	logic              in_sound;
	logic              is_ctrl;
	logic              is_bankreg;
	logic [BANK_W-1:0] eff_mask;
	logic [BANK_W-1:0] bank_sel;
	logic [BANK_W-1:0] bank0;
	logic [1:0]        high_new;
	logic [BANK_W-1:0] ctrl_bank0;
	logic [BANK_W-1:0] wr_bank;

	// address classification
	assign page       = item.address[14:13];
	assign off        = item.address[12:0];
	assign wr         = (item.opcode == OP_WRITE);
	assign scsi       = (high_cur == HIGH_SCSI);
	assign we         = high_cur[1];
	// bus 0x9800-0x9fff
	assign in_sound   = sound_cur && (item.address[14:11] == 4'b1011);
	// bus 0x7ffe-0x7fff
	assign is_ctrl    = (item.address[14:1] == 14'h1fff);
	// page offset 0x1000-0x17ff
	assign is_bankreg = (item.address[12:11] == 2'b10);
	assign eff_mask   = bank_mask & LIMIT;
	assign bank_sel   = BANK_W'(bank_cur[page]);
	assign bank0      = BANK_W'(bank_cur[0]);

	// control register write: new high bits and re-derived page 0 bank
	always_comb begin
		high_new = {item.write_data[4], board_type & item.write_data[6]};
		if (high_new == HIGH_SCSI) begin
			ctrl_bank0 = {1'b0, bank0[5:0]} & LIMIT;
		end else begin
			ctrl_bank0 = {high_new[0], bank0[5:0]} & eff_mask;
		end
	end

	// bank register write value, page 0 carries bank bit 6 outside scsi mode
	always_comb begin
		wr_bank = {1'b0, item.write_data[5:0]};
		if (page == 2'd0 && !scsi) begin
			wr_bank[6] = high_cur[0];
		end
		wr_bank = wr_bank & eff_mask;
	end

	// target selection in priority order
	always_comb begin
		res.target        = TGT_NONE;
		res.sram_address  = '0;
		res.device_offset = '0;
		res.write_strobe  = 1'b0;
		bank_nxt          = bank_cur;
		high_nxt          = high_cur;
		sound_nxt         = sound_cur;
		if (scsi && page == 2'd0) begin
			if (!off[12]) begin
				res.target = TGT_SCSI_DATA;
			end else begin
				res.target        = TGT_SCSI_REG;
				res.device_offset = {4'd0, off[3:0]};
			end
			res.write_strobe = wr;
		end else if (in_sound) begin
			res.target        = TGT_SOUND;
			res.device_offset = item.address[7:0];
			res.write_strobe  = wr;
		end else if (!wr) begin
			res.target       = TGT_SRAM;
			res.sram_address = {bank_sel, off};
		end else if (is_ctrl) begin
			if (high_new != high_cur) begin
				high_nxt    = high_new;
				bank_nxt[0] = ctrl_bank0[BANK_BITS-1:0];
			end
			res.target       = TGT_CTRL;
			res.write_strobe = 1'b1;
		end else if (we && !page[1]) begin
			res.target       = TGT_SRAM;
			res.sram_address = {bank_sel, off};
			res.write_strobe = 1'b1;
		end else if (is_bankreg && (page[1] || !we)) begin
			bank_nxt[page] = wr_bank[BANK_BITS-1:0];
			if (page == 2'd2) begin
				sound_nxt = (item.write_data[5:0] == 6'h3f);
			end
			res.target       = TGT_CTRL;
			res.write_strobe = 1'b1;
		end
		res.data_out = res.write_strobe ? item.write_data : 8'd0;
	end

endmodule

### hdl/sram_bank_mapper_with_device_windows_unit.sv
// Cartridge bank mapper: each bus access beat on the s_ side is decoded into
// one result beat on the m_ side (banked sram address, sound window, scsi
// data or register, control update, or none). One beat is accepted per clock
// when the output side keeps up; a beat enters an input register, is decoded
// against the bank and control registers (which it updates as it passes to the
// output register) and is held in the output register until taken. board_type
// and bank_mask are written over the apb port; the user must write them only
// while no beat is in flight, as the block itself does not enforce this.
module sram_bank_mapper_with_device_windows_unit import sbm_pkg::*; #(
	parameter int BANK_BITS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	// access beats
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,  // address[14:0], write_data[22:15], zero pad
	input  logic               s_tuser,  // opcode
	// result beats
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,  // sram_address[19:0], device_offset[27:20],
	                                     // write_strobe[28], data_out[36:29], zero pad
	output logic [2:0]         m_tuser,  // target
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic                 valid_s1;
	sbm_item_t            item_s1;
	logic                 valid_s2;
	sbm_result_t          res_s2;
	logic                 advance;
	logic                 board_type_q;
	logic [BANK_W-1:0]    bank_mask_q;
	logic [BANK_BITS-1:0] bank_q [4];
	logic [1:0]           high_q;
	logic                 sound_q;
	sbm_result_t          res_d;
	logic [BANK_BITS-1:0] bank_d [4];
	logic [1:0]           high_d;
	logic                 sound_d;
	logic                 cfg_wr;

	// handshake
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.target;
	assign m_tdata  = {3'd0, res_s2.data_out, res_s2.write_strobe,
		res_s2.device_offset, res_s2.sram_address};

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_BOARD_TYPE: prdata = {31'd0, board_type_q};
			REG_BANK_MASK:  prdata = {25'd0, bank_mask_q};
			default:        prdata = '0;
		endcase
	end

	// decode
	sbm_decode #(
		.BANK_BITS (BANK_BITS)
	) u_decode (
		.item       (item_s1),
		.board_type (board_type_q),
		.bank_mask  (bank_mask_q),
		.bank_cur   (bank_q),
		.high_cur   (high_q),
		.sound_cur  (sound_q),
		.res        (res_d),
		.bank_nxt   (bank_d),
		.high_nxt   (high_d),
		.sound_nxt  (sound_d)
	);

	// control, configuration and mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			board_type_q <= 1'b0;
			bank_mask_q  <= BANK_W'(15);
			high_q       <= 2'b00;
			sound_q      <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				bank_q[i] <= BANK_BITS'(i);
			end
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_BOARD_TYPE: board_type_q <= pwdata[0];
					REG_BANK_MASK:  bank_mask_q  <= pwdata[BANK_W-1:0];
					default:        board_type_q <= board_type_q;
				endcase
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				bank_q  <= bank_d;
				high_q  <= high_d;
				sound_q <= sound_d;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode     <= s_tuser;
			item_s1.address    <= s_tdata[14:0];
			item_s1.write_data <= s_tdata[22:15];
		end
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

### hdl/sbm_port_check.sv
// port level checks of the bank mapper, bound to the top level
`include "sram_bank_mapper_with_device_windows_unit_defines.svh"

module sbm_port_check import sbm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// stalled result beat holds
	`SBM_ASSERT(a_out_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result beat changed while stalled")

	// no result during reset
	`SBM_ASSERT_RST(a_rst_idle, (!arst_n |-> !m_tvalid), "result valid during reset")

	// data byte only with a write strobe
	`SBM_ASSERT(a_data_zero, (m_tvalid && !m_tdata[28] |-> m_tdata[36:29] == 8'd0), "data without strobe")

	// sram address only for sram targets
	`SBM_ASSERT(a_sram_zero, (m_tvalid && m_tuser != TGT_SRAM |-> m_tdata[19:0] == 20'd0), "sram address on other target")

	// open bus carries nothing
	`SBM_ASSERT(a_none_quiet, (m_tvalid && m_tuser == TGT_NONE |-> !m_tdata[28] && m_tdata[27:20] == 8'd0), "open bus beat not empty")

endmodule

bind sram_bank_mapper_with_device_windows_unit sbm_port_check u_port_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### dv/bank_map_checker_pkg.sv
// decode checker class and access map constants for the bank mapper testbench
`timescale 1ns / 1ps

package bank_map_checker_pkg;
	import sbm_pkg::*;

	// bus map seen from the cartridge slot
	localparam logic [15:0] BUS_BASE       = 16'h4000;
	localparam logic [15:0] CTRL_BUS       = 16'h7FFF;
	localparam logic [15:0] BANK_SEL_MASK  = 16'h1800;
	localparam logic [15:0] BANK_SEL_MATCH = 16'h1000;
	localparam logic [15:0] SOUND_LO       = 16'h9800;
	localparam logic [15:0] SOUND_HI       = 16'hA000;
	localparam logic [12:0] SCSI_REG_START = 13'h1000;
	localparam logic [5:0]  SOUND_BANK     = 6'h3F;
	localparam logic [6:0]  BANK_LIMIT     = 7'h7F;

	// access addresses (bus address minus the slot base)
	localparam logic [14:0] CTRL_ADDR   = 15'h3FFE;
	localparam logic [14:0] SOUND_ADDR  = 15'h5800;

	// control byte bits
	localparam logic [7:0] CTRL_WE    = 8'h10;
	localparam logic [7:0] CTRL_BANK6 = 8'h40;

	localparam logic OP_READ = ~OP_WRITE;

	class bank_map_checker;
		bit          board_type;
		bit [6:0]    bank_mask;
		bit [6:0]    bank_num[4];
		bit [1:0]    high_bits;
		bit          sound_on;
		sbm_result_t decoded_accesses[$];
		int          mismatches;

		function new();
			board_type = 1'b0;
			bank_mask  = 7'd15;
			high_bits  = 2'b00;
			sound_on   = 1'b0;
			mismatches = 0;
			for (int i = 0; i < 4; i++)
				bank_num[i] = 7'(i);
		endfunction

		function void configure(logic sel, logic [6:0] value);
			if (sel == REG_BOARD_TYPE)
				board_type = value[0];
			else
				bank_mask = value;
		endfunction

		// bank register write, page 0 carries bank bit 6 outside scsi mode
		function void set_bank(bit [1:0] page, bit [7:0] value);
			bit [6:0] v;
			v = {1'b0, value[5:0]};
			if (page == 2'd0) begin
				if (high_bits == HIGH_SCSI) begin
					bank_num[0] = v & bank_mask;
					return;
				end
				v[6] = high_bits[0];
			end else if (page == 2'd2) begin
				sound_on = (value[5:0] == SOUND_BANK);
			end
			bank_num[page] = v & bank_mask;
		endfunction

		// control byte write, page 0 bank is rebuilt when the bits change
		function void set_high(bit [7:0] value);
			bit [1:0] nh;
			nh = {value[4], board_type ? value[6] : 1'b0};
			if (nh == high_bits)
				return;
			high_bits = nh;
			if (nh == HIGH_SCSI)
				bank_num[0] = {1'b0, bank_num[0][5:0]} & BANK_LIMIT;
			else
				bank_num[0] = {nh[0], bank_num[0][5:0]} & bank_mask;
		endfunction

		// decode one access and update the mapper state it touches
		function sbm_result_t decode_access(logic op, logic [14:0] addr, logic [7:0] wdata);
			sbm_result_t r;
			bit [1:0]    page;
			bit [12:0]   off;
			bit [15:0]   bus;
			bit          in_sound;
			bit          we;
			page     = addr[14:13];
			off      = addr[12:0];
			bus      = {1'b0, addr} + BUS_BASE;
			in_sound = sound_on && bus >= SOUND_LO && bus < SOUND_HI;
			we       = high_bits[1];
			r        = '0;
			r.target = TGT_NONE;
			if (high_bits == HIGH_SCSI && page == 2'd0) begin
				if (off < SCSI_REG_START) begin
					r.target = TGT_SCSI_DATA;
				end else begin
					r.target = TGT_SCSI_REG;
					r.device_offset = {4'd0, off[3:0]};
				end
				r.write_strobe = op;
			end else if (in_sound) begin
				r.target = TGT_SOUND;
				r.device_offset = bus[7:0];
				r.write_strobe = op;
			end else if (op != OP_WRITE) begin
				r.target = TGT_SRAM;
				r.sram_address = {bank_num[page], off};
			end else if ((bus | 16'h0001) == CTRL_BUS) begin
				set_high(wdata);
				r.target = TGT_CTRL;
				r.write_strobe = 1'b1;
			end else if (we && page < 2'd2) begin
				r.target = TGT_SRAM;
				r.sram_address = {bank_num[page], off};
				r.write_strobe = 1'b1;
			end else if ((bus & BANK_SEL_MASK) == BANK_SEL_MATCH && (page >= 2'd2 || !we)) begin
				set_bank(page, wdata);
				r.target = TGT_CTRL;
				r.write_strobe = 1'b1;
			end
			r.data_out = r.write_strobe ? wdata : 8'h00;
			return r;
		endfunction

		function void note_access(logic op, logic [14:0] addr, logic [7:0] wdata);
			decoded_accesses.push_back(decode_access(op, addr, wdata));
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// compare one result beat against the oldest decoded access
		task check_result(logic [2:0] tgt, logic [39:0] tdata);
			sbm_result_t want;
			if (decoded_accesses.size() == 0) begin
				report_mismatch($sformatf("result beat with no access pending, target %0d", tgt));
				return;
			end
			want = decoded_accesses.pop_front();
			if (tgt !== want.target)
				report_mismatch($sformatf("target %0d, want %0d", tgt, want.target));
			if (tdata[19:0] !== want.sram_address)
				report_mismatch($sformatf("sram_address %h, want %h", tdata[19:0],
					want.sram_address));
			if (tdata[27:20] !== want.device_offset)
				report_mismatch($sformatf("device_offset %h, want %h", tdata[27:20],
					want.device_offset));
			if (tdata[28] !== want.write_strobe)
				report_mismatch($sformatf("write_strobe %b, want %b", tdata[28],
					want.write_strobe));
			if (tdata[36:29] !== want.data_out)
				report_mismatch($sformatf("data_out %h, want %h", tdata[36:29], want.data_out));
		endtask
	endclass

endpackage

### dv/testbench.sv
// top of the bank mapper testbench: clock, reset, access and register drivers
`timescale 1ns / 1ps

module testbench;
	import sbm_pkg::*;
	import bank_map_checker_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 180;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [23:0]        s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [39:0]        m_tdata;
	logic [2:0]         m_tuser;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	bank_map_checker checker_h = new();
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_tick = 0;
	int stall_mode = 0;

	sram_bank_mapper_with_device_windows_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern, with a randomly redrawn mode
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 256 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (stall_tick % 7) > 1;
			default: m_tready <= $urandom_range(0, 1);
		endcase
	end

	// result beat monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			checker_h.check_result(m_tuser, m_tdata);
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// one access beat, with a random gap at the start of each burst
	task automatic send_access(logic op, logic [14:0] addr, logic [7:0] wdata);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, wdata, addr};
		do @(posedge clk); while (!s_tready);
		checker_h.note_access(op, addr, wdata);
		burst_left--;
	endtask

	// stop sending and let every pending result come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (checker_h.decoded_accesses.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// apb write followed by a read back of the same register
	task automatic set_register(logic sel, logic [6:0] value);
		logic [31:0] want;
		logic [31:0] got;
		want = (sel == REG_BOARD_TYPE) ? {31'd0, value[0]} : {25'd0, value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		checker_h.configure(sel, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want)
			checker_h.report_mismatch($sformatf("register %0d reads %h, want %h", sel, got, want));
	endtask

	// random access biased toward the decoded regions
	task automatic send_random_access();
		int          kind;
		logic [1:0]  page;
		logic        op;
		logic [14:0] addr;
		logic [7:0]  wdata;
		kind  = $urandom_range(0, 9);
		page  = 2'($urandom_range(0, 3));
		op    = ($urandom_range(0, 9) < 6) ? OP_WRITE : OP_READ;
		wdata = 8'($urandom_range(0, 255));
		case (kind)
			2, 3: begin
				addr = {page, 2'b10, 11'($urandom_range(0, 2047))};
				if (page == 2'd2 && $urandom_range(0, 2) == 0)
					wdata = {wdata[7:6], SOUND_BANK};
			end
			4: addr = CTRL_ADDR | 15'($urandom_range(0, 1));
			5: addr = SOUND_ADDR | 15'($urandom_range(0, 2047));
			6: addr = {2'b00, 13'($urandom_range(0, 8191))};
			default: addr = 15'($urandom_range(0, 32767));
		endcase
		send_access(op, addr, wdata);
	endtask

	task automatic run_phase(logic board, logic [6:0] mask);
		wait_drained();
		set_register(REG_BOARD_TYPE, {6'd0, board});
		set_register(REG_BANK_MASK, mask);
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			// hold off once per phase until all results are back
			if (i == ITEMS_PER_PHASE / 2)
				wait_drained();
			send_random_access();
		end
	endtask

	initial begin
		// reset edge lands after every process is waiting on it
		arst_n   <= 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain board, smallest sram
		set_register(REG_BOARD_TYPE, 7'd0);
		set_register(REG_BANK_MASK, 7'd15);
		send_access(OP_READ,  15'h0000, 8'hFF);
		send_access(OP_READ,  15'h7FFF, 8'h00);
		send_access(OP_WRITE, 15'h3000, 8'hFF);
		send_access(OP_READ,  15'h3FFF, 8'h00);
		send_access(OP_WRITE, 15'h5000, {2'b00, SOUND_BANK});
		send_access(OP_READ,  SOUND_ADDR, 8'h00);
		send_access(OP_WRITE, 15'h5FFF, 8'hA5);
		send_access(OP_WRITE, 15'h4000, 8'h11);
		send_access(OP_WRITE, CTRL_ADDR, CTRL_WE);
		send_access(OP_WRITE, 15'h0123, 8'h5A);
		send_access(OP_WRITE, 15'h3000, 8'h07);
		send_access(OP_WRITE, 15'h7000, 8'h02);
		send_access(OP_READ,  15'h6000, 8'h00);
		send_access(OP_WRITE, CTRL_ADDR | 15'h1, CTRL_WE | CTRL_BANK6);
		send_access(OP_WRITE, CTRL_ADDR | 15'h1, 8'h00);
		send_access(OP_WRITE, 15'h17FF, 8'h3E);
		send_access(OP_READ,  15'h1000, 8'h00);
		send_access(OP_WRITE, 15'h5000, 8'h00);
		send_access(OP_READ,  SOUND_ADDR, 8'h00);

		// scsi board, largest sram
		wait_drained();
		set_register(REG_BOARD_TYPE, 7'd1);
		set_register(REG_BANK_MASK, 7'd127);
		send_access(OP_WRITE, CTRL_ADDR, CTRL_BANK6);
		send_access(OP_READ,  15'h0000, 8'h00);
		send_access(OP_WRITE, 15'h0FFF, 8'hC3);
		send_access(OP_WRITE, 15'h1ABC, 8'h3C);
		send_access(OP_READ,  15'h1FFF, 8'h00);
		send_access(OP_WRITE, CTRL_ADDR, CTRL_WE | CTRL_BANK6);
		send_access(OP_READ,  15'h0000, 8'h00);
		send_access(OP_WRITE, CTRL_ADDR, 8'h00);

		run_phase(1'b1, 7'd127);
		run_phase(1'b0, 7'd31);
		run_phase(1'b1, 7'd15);
		run_phase(1'b0, 7'd127);
		run_phase(1'b1, 7'd63);

		// drain and settle
		wait_drained();
		repeat (8) @(posedge clk);
		if (checker_h.decoded_accesses.size() != 0)
			checker_h.report_mismatch($sformatf("%0d results never arrived",
				checker_h.decoded_accesses.size()));
		if (checker_h.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/sbm_pkg.sv
hdl/sbm_decode.sv
hdl/sram_bank_mapper_with_device_windows_unit.sv
hdl/sbm_port_check.sv
dv/bank_map_checker_pkg.sv
dv/testbench.sv
